### rtl/core/fdtd1d_pkg.sv
`default_nettype none

package fdtd1d_pkg;

  // storage geometry
  localparam int unsigned MAX_CELLS = 2048;
  localparam int unsigned ADDR_W    = $clog2(MAX_CELLS);
  localparam int unsigned MIN_CELLS = 3;

  // field and coefficient formats
  localparam int unsigned FIELD_W = 16;               // Q4.12
  localparam int unsigned COEF_W  = 16;               // unsigned Q1.15
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned DIFF_W  = FIELD_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + COEF_W + 1;
  localparam int unsigned ACC_W   = PROD_W - FRAC_W + 1;
  localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

  // configuration registers
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CELLS_W    = 12;

  localparam logic [REG_IDX_W-1:0] REG_COURANT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOUNDARY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS    = 2'd2;

  localparam logic [COEF_W-1:0]  COEF_RESET  = COEF_W'(32768);
  localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(2001);

  // commands
  localparam int unsigned CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [ADDR_W-1:0]         cell_index;
    logic signed [FIELD_W-1:0] e_in;
    logic signed [FIELD_W-1:0] b_in;
  } cmd_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] e_out;
    logic signed [FIELD_W-1:0] b_out;
    logic                      status;
    logic                      saturated;
  } res_t;

  // one store port request
  typedef struct packed {
    logic                      re;
    logic [ADDR_W-1:0]         raddr;
    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic signed [FIELD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } sweep_stat_t;

  typedef struct packed {
    logic                      sat;
    logic signed [FIELD_W-1:0] val;
  } upd_t;

  // old + floor((prod + half) / 2^FRAC_W), saturated to the field range
  function automatic upd_t step_cell(logic signed [FIELD_W-1:0] old_v,
                                     logic signed [PROD_W-1:0]  prod);
    logic signed [PROD_W-1:0] rnd;
    logic signed [ACC_W-1:0]  acc;
    upd_t                     r;
    rnd = prod + PROD_W'(ROUND_HALF);
    acc = ACC_W'(rnd >>> FRAC_W) + ACC_W'(old_v);
    if ((&acc[ACC_W-1:FIELD_W-1]) || (~|acc[ACC_W-1:FIELD_W-1])) begin
      r.sat = 1'b0;
      r.val = acc[FIELD_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = acc[ACC_W-1] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // index of the last active cell, n clamped to [MIN_CELLS, MAX_CELLS]
  function automatic logic [ADDR_W-1:0] last_cell(logic [CELLS_W-1:0] cells);
    logic [ADDR_W-1:0] r;
    if (cells < CELLS_W'(MIN_CELLS)) begin
      r = ADDR_W'(MIN_CELLS - 1);
    end else if (32'(cells) > MAX_CELLS) begin
      r = ADDR_W'(MAX_CELLS - 1);
    end else begin
      r = ADDR_W'(cells - CELLS_W'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fdtd1d_ram.sv
`default_nettype none

module fdtd1d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/fdtd1d_sweep.sv
`default_nettype none

// One time step as a single streaming pass: read cell k of both stores,
// update E[k] from old B, then B[k-1] from new E. Two end writes follow.
module fdtd1d_sweep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [fdtd1d_pkg::COEF_W-1:0]        coef_i,
  input  logic                                 open_i,
  input  logic [fdtd1d_pkg::ADDR_W-1:0]        last_i,
  output fdtd1d_pkg::mem_req_t                 e_req_o,
  input  logic signed [fdtd1d_pkg::FIELD_W-1:0] e_rdata_i,
  output fdtd1d_pkg::mem_req_t                 b_req_o,
  input  logic signed [fdtd1d_pkg::FIELD_W-1:0] b_rdata_i,
  output fdtd1d_pkg::sweep_stat_t              stat_o
);

  typedef enum logic [2:0] {
    SW_IDLE,
    SW_RUN,
    SW_DRAIN,
    SW_EDGE_LO,
    SW_EDGE_HI
  } state_e;

  state_e                               state_q;
  logic [fdtd1d_pkg::ADDR_W-1:0]        k0_q;
  logic                                 done_q;
  logic                                 sat_q;

  logic                                 v1_q, v2_q, v3_q, v4_q;
  logic [fdtd1d_pkg::ADDR_W-1:0]        k1_q, k2_q, k3_q, k4_q;
  logic [fdtd1d_pkg::ADDR_W-1:0]        last_m1;

  logic signed [fdtd1d_pkg::FIELD_W-1:0] bprev_q, elast_q;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] eold2_q, bold2_q;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] enew3_q, eprev3_q, bold3_q;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] bold4_q;
  logic signed [fdtd1d_pkg::PROD_W-1:0]  prod_e2_q, prod_b4_q;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] e_lo_q, e_hi_q, b_lo_q, b_hi_q;

  logic signed [fdtd1d_pkg::DIFF_W-1:0]  diff_e, diff_b;
  logic signed [fdtd1d_pkg::PROD_W-1:0]  prod_e, prod_b;
  fdtd1d_pkg::upd_t                      upd_e, upd_b;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] e_new;
  logic                                  sat_hit;

  assign last_m1 = last_i - fdtd1d_pkg::ADDR_W'(1);

  // stage 1: E difference from old B, multiply
  assign diff_e = fdtd1d_pkg::DIFF_W'(bprev_q) - fdtd1d_pkg::DIFF_W'(b_rdata_i);
  assign prod_e = $signed({1'b0, coef_i}) * diff_e;

  // stage 2: E accumulate; cell 0 passes through unchanged
  assign upd_e = fdtd1d_pkg::step_cell(eold2_q, prod_e2_q);
  assign e_new = (k2_q == '0) ? eold2_q : upd_e.val;

  // stage 3: B difference from new E, multiply
  assign diff_b = fdtd1d_pkg::DIFF_W'(eprev3_q) - fdtd1d_pkg::DIFF_W'(enew3_q);
  assign prod_b = $signed({1'b0, coef_i}) * diff_b;

  // stage 4: B accumulate for cell k4-1
  assign upd_b = fdtd1d_pkg::step_cell(bold4_q, prod_b4_q);

  assign sat_hit = (v2_q && (k2_q != '0) && upd_e.sat) ||
                   (v4_q && (k4_q != '0) && upd_b.sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SW_IDLE;
      k0_q    <= '0;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (sat_hit) begin
        sat_q <= 1'b1;
      end
      case (state_q)
        SW_IDLE: begin
          if (go_i) begin
            state_q <= SW_RUN;
            k0_q    <= '0;
            sat_q   <= 1'b0;
          end
        end
        SW_RUN: begin
          if (k0_q == last_i) begin
            state_q <= SW_DRAIN;
          end else begin
            k0_q <= k0_q + fdtd1d_pkg::ADDR_W'(1);
          end
        end
        SW_DRAIN: begin
          if (v4_q && (k4_q == last_i)) begin
            state_q <= SW_EDGE_LO;
          end
        end
        SW_EDGE_LO: begin
          state_q <= SW_EDGE_HI;
        end
        SW_EDGE_HI: begin
          state_q <= SW_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= SW_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= (state_q == SW_RUN);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q <= k0_q;
    if (v1_q) begin
      bprev_q   <= b_rdata_i;
      k2_q      <= k1_q;
      eold2_q   <= e_rdata_i;
      bold2_q   <= bprev_q;
      prod_e2_q <= prod_e;
    end
    if (v2_q) begin
      elast_q  <= e_new;
      k3_q     <= k2_q;
      enew3_q  <= e_new;
      eprev3_q <= elast_q;
      bold3_q  <= bold2_q;
      if (k2_q == fdtd1d_pkg::ADDR_W'(1)) begin
        e_lo_q <= e_new;
      end
      if (k2_q == last_m1) begin
        e_hi_q <= e_new;
      end
    end
    if (v3_q) begin
      k4_q      <= k3_q;
      bold4_q   <= bold3_q;
      prod_b4_q <= prod_b;
    end
    if (v4_q) begin
      if (k4_q == fdtd1d_pkg::ADDR_W'(2)) begin
        b_lo_q <= upd_b.val;
      end
      if (k4_q == last_i) begin
        b_hi_q <= upd_b.val;
      end
    end
  end

  always_comb begin
    e_req_o       = '0;
    b_req_o       = '0;
    e_req_o.re    = (state_q == SW_RUN);
    e_req_o.raddr = k0_q;
    b_req_o.re    = (state_q == SW_RUN);
    b_req_o.raddr = k0_q;
    e_req_o.we    = v2_q && (k2_q != '0);
    e_req_o.waddr = k2_q;
    e_req_o.wdata = e_new;
    b_req_o.we    = v4_q && (k4_q != '0);
    b_req_o.waddr = k4_q - fdtd1d_pkg::ADDR_W'(1);
    b_req_o.wdata = upd_b.val;
    case (state_q)
      SW_EDGE_LO: begin
        e_req_o.we    = 1'b1;
        e_req_o.waddr = '0;
        e_req_o.wdata = open_i ? e_lo_q : '0;
        b_req_o.we    = 1'b1;
        b_req_o.waddr = '0;
        b_req_o.wdata = open_i ? b_lo_q : '0;
      end
      SW_EDGE_HI: begin
        e_req_o.we    = 1'b1;
        e_req_o.waddr = last_i;
        e_req_o.wdata = open_i ? e_hi_q : '0;
        b_req_o.we    = 1'b1;
        b_req_o.waddr = last_i;
        b_req_o.wdata = open_i ? b_hi_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;

  // writes trail the read pointer, so no cell is read after its update
  a_e_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SW_RUN) && e_req_o.we |-> e_req_o.waddr < k0_q)
    else $error("E write not behind read pointer");

  a_b_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SW_RUN) && b_req_o.we |-> b_req_o.waddr < k0_q)
    else $error("B write not behind read pointer");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !v1_q && !v2_q && !v3_q && !v4_q)
    else $error("step done with pipeline still busy");

endmodule

`default_nettype wire

### rtl/core/fdtd_1d_field_engine.sv
`default_nettype none

// Channel   | Direction | Handshake                     | Beat
// ----------+-----------+-------------------------------+--------------------------------
// command   | in        | start & !busy                 | cmd_i   (command, index, e, b)
// result    | out       | done_o, one-cycle strobe      | res_o   (e, b, status, sat)
// config    | in        | cfg_valid_i & cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Write: result in the cycle after accept, busy stays low.
// Read: registered store read, then the registered result.
// Advance: result after the sweep; one cell per cycle over the single
//   read port of each store, plus pipeline fill and the two end-cell writes.
// Reset restores the config registers; the field stores are not cleared.
// The result is a strobe the receiver cannot stall; cfg_ready_o is always high.
module fdtd_1d_field_engine (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  fdtd1d_pkg::cmd_t                      cmd_i,
  output logic                                  done_o,
  output fdtd1d_pkg::res_t                      res_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fdtd1d_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [fdtd1d_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ADV
  } state_e;

  state_e                                state_q;
  logic                                  done_q;
  fdtd1d_pkg::res_t                      res_q;
  logic                                  rd_ok_q;

  // configuration registers
  logic [fdtd1d_pkg::COEF_W-1:0]         coef_q;
  logic                                  open_q;
  logic [fdtd1d_pkg::CELLS_W-1:0]        cells_q;
  logic [fdtd1d_pkg::ADDR_W-1:0]         last_idx;

  logic                                  accept;
  logic                                  idx_ok;
  logic                                  go;

  fdtd1d_pkg::mem_req_t                  cmd_e_req, cmd_b_req;
  fdtd1d_pkg::mem_req_t                  sw_e_req, sw_b_req;
  fdtd1d_pkg::mem_req_t                  e_req, b_req;
  fdtd1d_pkg::sweep_stat_t               sw_stat;
  logic signed [fdtd1d_pkg::FIELD_W-1:0] e_rdata, b_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= fdtd1d_pkg::COEF_RESET;
      open_q  <= 1'b0;
      cells_q <= fdtd1d_pkg::CELLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fdtd1d_pkg::REG_COURANT:  coef_q  <= cfg_data_i[fdtd1d_pkg::COEF_W-1:0];
        fdtd1d_pkg::REG_BOUNDARY: open_q  <= cfg_data_i[0];
        fdtd1d_pkg::REG_CELLS:    cells_q <= cfg_data_i[fdtd1d_pkg::CELLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign last_idx = fdtd1d_pkg::last_cell(cells_q);

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign idx_ok = (cmd_i.cell_index <= last_idx);
  assign go     = accept && (cmd_i.command == fdtd1d_pkg::CMD_ADVANCE);

  // single-cell access from write and read commands
  always_comb begin
    cmd_e_req       = '0;
    cmd_b_req       = '0;
    cmd_e_req.re    = accept && (cmd_i.command == fdtd1d_pkg::CMD_READ) && idx_ok;
    cmd_e_req.raddr = cmd_i.cell_index;
    cmd_e_req.we    = accept && (cmd_i.command == fdtd1d_pkg::CMD_WRITE) && idx_ok;
    cmd_e_req.waddr = cmd_i.cell_index;
    cmd_e_req.wdata = cmd_i.e_in;
    cmd_b_req.re    = cmd_e_req.re;
    cmd_b_req.raddr = cmd_i.cell_index;
    cmd_b_req.we    = cmd_e_req.we;
    cmd_b_req.waddr = cmd_i.cell_index;
    cmd_b_req.wdata = cmd_i.b_in;
  end

  // the sweep owns both stores for the whole step
  assign e_req = (state_q == ST_ADV) ? sw_e_req : cmd_e_req;
  assign b_req = (state_q == ST_ADV) ? sw_b_req : cmd_b_req;

  fdtd1d_ram #(
    .WIDTH (fdtd1d_pkg::FIELD_W),
    .DEPTH (fdtd1d_pkg::MAX_CELLS)
  ) u_e_ram (
    .clk_i   (clk_i),
    .we_i    (e_req.we),
    .waddr_i (e_req.waddr),
    .wdata_i (e_req.wdata),
    .re_i    (e_req.re),
    .raddr_i (e_req.raddr),
    .rdata_o (e_rdata)
  );

  fdtd1d_ram #(
    .WIDTH (fdtd1d_pkg::FIELD_W),
    .DEPTH (fdtd1d_pkg::MAX_CELLS)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_req.we),
    .waddr_i (b_req.waddr),
    .wdata_i (b_req.wdata),
    .re_i    (b_req.re),
    .raddr_i (b_req.raddr),
    .rdata_o (b_rdata)
  );

  fdtd1d_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .coef_i    (coef_q),
    .open_i    (open_q),
    .last_i    (last_idx),
    .e_req_o   (sw_e_req),
    .e_rdata_i (e_rdata),
    .b_req_o   (sw_b_req),
    .b_rdata_i (b_rdata),
    .stat_o    (sw_stat)
  );

  // command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_i.command)
              fdtd1d_pkg::CMD_WRITE: begin
                done_q <= 1'b1;
                res_q  <= '{e_out: '0, b_out: '0, status: !idx_ok, saturated: 1'b0};
              end
              fdtd1d_pkg::CMD_READ: begin
                state_q <= ST_READ;
                rd_ok_q <= idx_ok;
              end
              fdtd1d_pkg::CMD_ADVANCE: begin
                state_q <= ST_ADV;
              end
              default: begin
                // unused code: empty result
                done_q <= 1'b1;
                res_q  <= '0;
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          res_q   <= '{e_out:     rd_ok_q ? e_rdata : '0,
                       b_out:     rd_ok_q ? b_rdata : '0,
                       status:    !rd_ok_q,
                       saturated: 1'b0};
        end
        ST_ADV: begin
          if (sw_stat.done) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            res_q   <= '{e_out: '0, b_out: '0, status: 1'b0, saturated: sw_stat.sat};
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_write_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i.command == fdtd1d_pkg::CMD_WRITE) |=> done_o && !busy)
    else $error("write result not in next cycle");

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i.command == fdtd1d_pkg::CMD_READ) |=> busy ##1 done_o)
    else $error("read result not two cycles after accept");

  a_sat_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated |-> $past(state_q == ST_ADV))
    else $error("saturation flag outside a time step");

endmodule

`default_nettype wire

### bench/fdtd_1d_field_engine_test.sv
`default_nettype none

module fdtd_1d_field_engine_test;
  import fdtd1d_pkg::*;

  // Command code 3 does nothing and answers with an all-zero result.
  localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
  // Register index 3 maps to nothing; a write there must not disturb the others.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint FIELD_MAX = (longint'(1) <<< (FIELD_W - 1)) - 1;
  localparam longint FIELD_MIN = -FIELD_MAX - 1;

  // Longest legal silence is one step over 2048 cells plus a short sender
  // gap; allow roughly ten times that.
  localparam int WATCHDOG_LIMIT = 20000;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  cmd_t                  cmd_beat    = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic busy;
  logic done_o;
  res_t res_o;
  logic cfg_ready_o;

  always #2 clk_i = ~clk_i;

  fdtd_1d_field_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_beat),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Field model: own copy of both stores and of the three registers
  // ---------------------------------------------------------------------------
  logic signed [FIELD_W-1:0] e_cells [MAX_CELLS];
  logic signed [FIELD_W-1:0] b_cells [MAX_CELLS];
  logic [COEF_W-1:0]         courant   = COEF_RESET;
  logic                      open_ends = 1'b0;
  logic [CELLS_W-1:0]        cells_cfg = CELLS_RESET;
  bit                        step_saturated;

  cmd_t queued_commands [$];   // beats waiting for the driver
  res_t field_answers   [$];   // predicted results, oldest first

  int idle_pct     = 0;
  int error_count  = 0;
  int reg_writes   = 0;
  int writes_seen  = 0;
  int reads_seen   = 0;
  int steps_seen   = 0;
  int steps_sat    = 0;
  int nops_seen    = 0;
  int outside_seen = 0;
  int quiet_cycles = 0;

  // n clamped to [3, MAX_CELLS]
  function automatic int unsigned live_cells();
    if (cells_cfg < MIN_CELLS) return MIN_CELLS;
    if (cells_cfg > MAX_CELLS) return MAX_CELLS;
    return cells_cfg;
  endfunction

  // old + round(c * diff / 2^15), half rounds up, then clamp to the field range
  function automatic logic signed [FIELD_W-1:0] field_add(logic signed [FIELD_W-1:0] old_v,
                                                          longint diff);
    longint acc;
    acc = longint'(old_v) +
          ((longint'(courant) * diff + longint'(ROUND_HALF)) >>> FRAC_W);
    if (acc > FIELD_MAX) begin
      step_saturated = 1'b1;
      acc = FIELD_MAX;
    end else if (acc < FIELD_MIN) begin
      step_saturated = 1'b1;
      acc = FIELD_MIN;
    end
    return FIELD_W'(acc);
  endfunction

  // Applies one accepted command to the model and returns the result it must give.
  function automatic res_t predict_answer(cmd_t c);
    res_t        r;
    int unsigned n;
    logic        in_range;
    n        = live_cells();
    in_range = c.cell_index < n;
    r        = '0;
    case (c.command)
      CMD_WRITE: begin
        if (in_range) begin
          e_cells[c.cell_index] = c.e_in;
          b_cells[c.cell_index] = c.b_in;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_ADVANCE: begin
        step_saturated = 1'b0;
        // E from old B, then B from new E
        for (int k = 1; k < n; k++) begin
          e_cells[k] = field_add(e_cells[k],
                                 longint'(b_cells[k-1]) - longint'(b_cells[k]));
        end
        for (int k = 0; k + 1 < n; k++) begin
          b_cells[k] = field_add(b_cells[k],
                                 longint'(e_cells[k]) - longint'(e_cells[k+1]));
        end
        if (open_ends) begin
          e_cells[0]   = e_cells[1];
          e_cells[n-1] = e_cells[n-2];
          b_cells[0]   = b_cells[1];
          b_cells[n-1] = b_cells[n-2];
        end else begin
          e_cells[0]   = '0;
          e_cells[n-1] = '0;
          b_cells[0]   = '0;
          b_cells[n-1] = '0;
        end
        r.saturated = step_saturated;
      end
      CMD_READ: begin
        if (in_range) begin
          r.e_out = e_cells[c.cell_index];
          r.b_out = b_cells[c.cell_index];
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly small values so steps do not saturate every time; some extremes.
  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(7))
      0:       return FIELD_W'($urandom);
      1:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return FIELD_W'($urandom_range(4095)) - 16'd2048;
    endcase
  endfunction

  // Mostly inside the active range, with the ends and the odd stray index.
  function automatic int unsigned rand_index(int unsigned n);
    case ($urandom_range(9))
      0:       return $urandom_range(MAX_CELLS - 1);
      1:       return n - 1;
      2:       return 0;
      default: return $urandom_range(n - 1);
    endcase
  endfunction

  task automatic queue_command(logic [CMD_W-1:0] op, int unsigned idx,
                               logic [FIELD_W-1:0] e_val, logic [FIELD_W-1:0] b_val);
    cmd_t c;
    c.command    = op;
    c.cell_index = ADDR_W'(idx);
    c.e_in       = e_val;
    c.b_in       = b_val;
    queued_commands.push_back(c);
  endtask

  task automatic fill_cells(int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++) begin
      queue_command(CMD_WRITE, i, rand_field(), rand_field());
    end
  endtask

  // One beat on the config channel; the model follows at the accepting edge.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_COURANT:  courant   = val;
      REG_BOUNDARY: open_ends = val[0];
      REG_CELLS:    cells_cfg = val[CELLS_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Block idle: every beat sent, every answer back, busy low.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (queued_commands.size() != 0 || start || field_answers.size() != 0 || busy);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats, holds them while busy, idles at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t answer;
    if (rst_ni) begin
      if (start && !busy) begin
        answer = predict_answer(cmd_beat);
        field_answers.push_back(answer);
        case (cmd_beat.command)
          CMD_WRITE:   writes_seen++;
          CMD_READ:    reads_seen++;
          CMD_ADVANCE: begin
            steps_seen++;
            if (answer.saturated) steps_sat++;
          end
          default:     nops_seen++;
        endcase
        if (answer.status) outside_seen++;
      end
      if (!start || !busy) begin
        if (queued_commands.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start    <= 1'b1;
          cmd_beat <= queued_commands.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result strobe against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string field_name, logic signed [FIELD_W-1:0] want,
                               logic signed [FIELD_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (field_answers.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected, got e=%0d b=%0d status=%0b sat=%0b",
                 $time, res_o.e_out, res_o.b_out, res_o.status, res_o.saturated);
      end else begin
        want = field_answers.pop_front();
        if (res_o.e_out !== want.e_out)         flag_mismatch("e_out", want.e_out, res_o.e_out);
        if (res_o.b_out !== want.b_out)         flag_mismatch("b_out", want.b_out, res_o.b_out);
        if (res_o.status !== want.status)       flag_mismatch("status", want.status, res_o.status);
        if (res_o.saturated !== want.saturated) flag_mismatch("saturated", want.saturated,
                                                              res_o.saturated);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any command, result or config beat counts as progress
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("** fdtd_1d_field_engine: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned cells_set;
    int unsigned coef_set;
    int unsigned pick;
    int unsigned step_pct;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (c = 1, conductor ends, n = 2001). Stores are undefined
    // after reset, so nothing reads or steps over a cell before it is loaded.
    // Only cells 0 to 23, 2000 and 2047 are ever loaded; every step and every
    // in-range access below stays on those.
    idle_pct = 0;
    queue_command(CMD_WRITE, 2001, rand_field(), rand_field());  // just past n: dropped
    queue_command(CMD_WRITE, MAX_CELLS - 1, 16'h7fff, 16'h8000);
    queue_command(CMD_NONE, $urandom_range(MAX_CELLS - 1), rand_field(), rand_field());
    queue_command(CMD_READ, MAX_CELLS - 1, rand_field(), rand_field());
    fill_cells(0, 23);
    queue_command(CMD_WRITE, 1, 16'h7fff, 16'h8000);
    queue_command(CMD_WRITE, 2, 16'h8000, 16'h7fff);
    queue_command(CMD_WRITE, 2000, rand_field(), rand_field());  // last cell of n
    queue_command(CMD_READ, 0, rand_field(), rand_field());
    queue_command(CMD_READ, 1, rand_field(), rand_field());
    queue_command(CMD_READ, 2, rand_field(), rand_field());
    queue_command(CMD_READ, 2000, rand_field(), rand_field());
    wait_quiet();

    // Oversized n clamps to the full store, so the top cell is now in range.
    // Then a short span with the largest gain and open ends.
    write_reg(REG_CELLS, 16'd4095);
    write_reg(REG_COURANT, 16'hffff);
    write_reg(REG_BOUNDARY, 16'd1);
    idle_pct = 54;
    queue_command(CMD_WRITE, MAX_CELLS - 1, 16'h7fff, 16'h8000);
    queue_command(CMD_READ, MAX_CELLS - 1, rand_field(), rand_field());
    queue_command(CMD_READ, 2000, rand_field(), rand_field());
    wait_quiet();
    write_reg(REG_CELLS, 16'd24);
    queue_command(CMD_ADVANCE, MAX_CELLS - 1, rand_field(), rand_field());
    queue_command(CMD_READ, 0, rand_field(), rand_field());
    queue_command(CMD_READ, 1, rand_field(), rand_field());
    queue_command(CMD_READ, 22, rand_field(), rand_field());
    queue_command(CMD_READ, 23, rand_field(), rand_field());
    wait_quiet();

    // n = 0 behaves as 3; zero gain leaves only the end-cell zeroing.
    write_reg(REG_CELLS, 16'd0);
    write_reg(REG_COURANT, 16'd0);
    write_reg(REG_BOUNDARY, 16'd0);
    write_reg(REG_UNUSED, 16'($urandom));
    idle_pct = 29;
    queue_command(CMD_WRITE, 2, 16'h8000, 16'h7fff);
    queue_command(CMD_WRITE, 3, rand_field(), rand_field());
    queue_command(CMD_READ, 3, rand_field(), rand_field());
    queue_command(CMD_ADVANCE, 0, rand_field(), rand_field());
    queue_command(CMD_READ, 0, rand_field(), rand_field());
    queue_command(CMD_READ, 1, rand_field(), rand_field());
    queue_command(CMD_READ, 2, rand_field(), rand_field());
    wait_quiet();

    // Random phases. Spans never exceed the 24 loaded cells, so an in-range
    // index always hits a loaded cell and any other reports out of range.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       cells_set = 3;
        2:       cells_set = 24;
        4:       cells_set = 1;
        default: cells_set = $urandom_range(4, 24);
      endcase
      case (p)
        0:       coef_set = 32768;
        3:       coef_set = 65535;
        default: coef_set = $urandom_range(32768);
      endcase
      write_reg(REG_CELLS, CFG_DATA_W'(cells_set));
      write_reg(REG_COURANT, CFG_DATA_W'(coef_set));
      write_reg(REG_BOUNDARY, CFG_DATA_W'(p % 2));
      case (p)
        1, 4:    idle_pct = 54;
        3, 5:    idle_pct = 29;
        default: idle_pct = 0;
      endcase
      n        = live_cells();
      step_pct = (n > 64) ? 6 : 24;
      for (int i = 0; i < 15; i++) begin
        pick = $urandom_range(99);
        if (pick < 36) begin
          queue_command(CMD_WRITE, rand_index(n), rand_field(), rand_field());
        end else if (pick < 72) begin
          queue_command(CMD_READ, rand_index(n), rand_field(), rand_field());
        end else if (pick < 72 + step_pct) begin
          queue_command(CMD_ADVANCE, $urandom_range(MAX_CELLS - 1), rand_field(),
                        rand_field());
        end else if (pick < 97) begin
          queue_command(CMD_READ, rand_index(n), rand_field(), rand_field());
        end else begin
          queue_command(CMD_NONE, $urandom_range(MAX_CELLS - 1), rand_field(), rand_field());
        end
      end
      wait_quiet();
    end

    // Let any stray strobe show up before the verdict.
    repeat (32) @(posedge clk_i);

    $display("Ran %0d writes, %0d reads, %0d steps (%0d saturating), %0d unused codes",
             writes_seen, reads_seen, steps_seen, steps_sat, nops_seen);
    $display("%0d beats out of range, %0d register writes, %0d mismatches",
             outside_seen, reg_writes, error_count);
    if (error_count == 0) begin
      $display("** fdtd_1d_field_engine: PASSED **");
    end else begin
      $display("** fdtd_1d_field_engine: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
